// ----- src/ils_pkg.sv -----
// Package for the indexed list store: field widths, operation and status codes,
// and the control word broadcast along the row of storage cells. No dependencies.
package ils_pkg;

	localparam int WORD_W     = 32;
	localparam int MODE_W     = 2;
	localparam int IDX_W      = 8;
	localparam int ST_W       = 2;
	localparam int CNT_OUT_W  = 9;
	localparam int DEF_DEPTH  = 256;
	localparam int MAX_DEPTH  = 4096;
	// Wide enough to hold any position or count up to MAX_DEPTH.
	localparam int POS_W      = $clog2(MAX_DEPTH + 1);
	localparam int GRP_SIZE   = 16;
	localparam int GRP_SEL_W  = $clog2(GRP_SIZE);
	localparam int MAX_GROUPS = (1 << IDX_W) / GRP_SIZE;

	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_OOB  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic                     op_append;
		logic                     op_update;
		logic                     op_delete;
		logic [POS_W-1:0]         pos;
		logic [POS_W-1:0]         count;
		logic signed [WORD_W-1:0] value;
	} cell_ctl_t;

endpackage

// ----- src/ils_req_if.sv -----
// Request channel of the indexed list store: valid/ready handshake with the
// operation, position and data word. Depends on ils_pkg.
interface ils_req_if;
	logic                             valid;
	logic                             ready;
	logic [ils_pkg::MODE_W-1:0]       mode;
	logic [ils_pkg::IDX_W-1:0]        index;
	logic signed [ils_pkg::WORD_W-1:0] value;

	modport source (output valid, output mode, output index, output value, input ready);
	modport sink (input valid, input mode, input index, input value, output ready);
endinterface

// ----- src/ils_rsp_if.sv -----
// Response channel of the indexed list store: valid/ready handshake with the
// read word, status and element count. Depends on ils_pkg.
interface ils_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [ils_pkg::WORD_W-1:0] read_data;
	logic [ils_pkg::ST_W-1:0]          status;
	logic [ils_pkg::CNT_OUT_W-1:0]     count;

	modport source (output valid, output read_data, output status, output count, input ready);
	modport sink (input valid, input read_data, input status, input count, output ready);
endinterface

// ----- src/ils_cell.sv -----
// One storage cell of the list: holds a word and decides from the broadcast
// control word whether to load new data or its upper neighbor. Depends on ils_pkg.
module ils_cell #(
	parameter int INDEX = 0
) (
	input  logic                              clk,
	input  ils_pkg::cell_ctl_t                ctl,
	input  logic signed [ils_pkg::WORD_W-1:0] nxt_word,
	output logic signed [ils_pkg::WORD_W-1:0] word_q
);

	localparam logic [ils_pkg::POS_W-1:0] MY_POS  = ils_pkg::POS_W'(INDEX);
	localparam logic [ils_pkg::POS_W-1:0] NXT_POS = ils_pkg::POS_W'(INDEX + 1);

	logic hit_app;
	logic hit_upd;
	logic hit_del;

	assign hit_app = ctl.op_append && (ctl.count == MY_POS);
	assign hit_upd = ctl.op_update && (ctl.pos == MY_POS);
	// On a delete every cell from the gap up to the second-to-last element
	// takes the word of its upper neighbor.
	assign hit_del = ctl.op_delete && (ctl.pos <= MY_POS) && (NXT_POS < ctl.count);

	always_ff @(posedge clk) begin
		if (hit_app || hit_upd) begin
			word_q <= ctl.value;
		end else if (hit_del) begin
			word_q <= nxt_word;
		end
	end

endmodule

// ----- src/ils_chain.sv -----
// Row of storage cells for the indexed list store, plus the first level of the
// registered read select (one word per group of sixteen). Depends on ils_pkg, ils_cell.
module ils_chain #(
	parameter int DEPTH = ils_pkg::DEF_DEPTH
) (
	input  logic                              clk,
	input  ils_pkg::cell_ctl_t                ctl,
	input  logic                              rd_cap,
	input  logic [ils_pkg::GRP_SEL_W-1:0]     rd_lo,
	output logic signed [ils_pkg::WORD_W-1:0] grp_s1 [ils_pkg::MAX_GROUPS]
);

	// Every position the index field can name; positions past the depth read as zero.
	localparam int PAD_CELLS = ils_pkg::MAX_GROUPS * ils_pkg::GRP_SIZE;

	logic signed [ils_pkg::WORD_W-1:0] words [DEPTH];
	logic signed [ils_pkg::WORD_W-1:0] pad [PAD_CELLS];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [ils_pkg::WORD_W-1:0] nxt;
		if (i + 1 < DEPTH) begin : g_mid
			assign nxt = words[i + 1];
		end else begin : g_last
			assign nxt = '0;
		end
		ils_cell #(.INDEX(i)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.nxt_word (nxt),
			.word_q   (words[i])
		);
	end

	for (genvar j = 0; j < PAD_CELLS; j++) begin : g_pad
		if (j < DEPTH) begin : g_real
			assign pad[j] = words[j];
		end else begin : g_zero
			assign pad[j] = '0;
		end
	end

	for (genvar g = 0; g < ils_pkg::MAX_GROUPS; g++) begin : g_grp
		logic signed [ils_pkg::WORD_W-1:0] grp_w [ils_pkg::GRP_SIZE];
		for (genvar k = 0; k < ils_pkg::GRP_SIZE; k++) begin : g_tap
			assign grp_w[k] = pad[g * ils_pkg::GRP_SIZE + k];
		end
		always_ff @(posedge clk) begin
			if (rd_cap) begin
				grp_s1[g] <= grp_w[rd_lo];
			end
		end
	end

endmodule

// ----- src/indexed_list_store_top.sv -----
// Indexed list store: ordered list of signed words held in a row of cells.
// Results pass two levels of registered read select (group word, then output register);
// one request is in flight at a time, so the next is taken once the result is loaded.
// Reset clears the element count and the control state; cell contents stay
// undefined until written, with no clearing pass. Depends on ils_pkg, ils_chain.
module indexed_list_store_top #(
	parameter int DEPTH = ils_pkg::DEF_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	ils_req_if.sink    req,
	ils_rsp_if.source  rsp
);

	localparam int CW         = $clog2(DEPTH + 1);
	localparam int HI_W       = ils_pkg::IDX_W - ils_pkg::GRP_SEL_W;
	localparam logic [ils_pkg::POS_W-1:0] DEPTH_POS = ils_pkg::POS_W'(DEPTH);

	logic [CW-1:0]                     count_q;
	logic                              busy_q;
	logic                              rsp_valid_q;
	logic signed [ils_pkg::WORD_W-1:0] rsp_data_q;
	logic [ils_pkg::ST_W-1:0]          rsp_st_q;
	logic [ils_pkg::CNT_OUT_W-1:0]     rsp_cnt_q;

	logic [ils_pkg::ST_W-1:0]          st_s1;
	logic [ils_pkg::CNT_OUT_W-1:0]     cnt_s1;
	logic                              rd_ok_s1;
	logic                              rd_oob_s1;
	logic [HI_W-1:0]                   grp_hi_s1;
	logic signed [ils_pkg::WORD_W-1:0] grp_s1 [ils_pkg::MAX_GROUPS];

	logic                       acc;
	logic                       full;
	logic                       oob;
	logic [ils_pkg::POS_W-1:0]  count_ext;
	logic [ils_pkg::POS_W-1:0]  count_nxt;
	logic [ils_pkg::ST_W-1:0]   st_nxt;
	logic                       is_app;
	logic                       is_rd;
	logic                       is_upd;
	logic                       is_del;
	logic                       rsp_load;
	logic signed [ils_pkg::WORD_W-1:0] rd_word;
	ils_pkg::cell_ctl_t         ctl;

	assign req.ready = !busy_q;
	assign acc       = req.valid && req.ready;

	assign count_ext = ils_pkg::POS_W'(count_q);
	assign full      = count_ext >= DEPTH_POS;
	assign oob       = ils_pkg::POS_W'(req.index) >= count_ext;
	assign is_app    = req.mode == ils_pkg::MODE_APPEND;
	assign is_rd     = req.mode == ils_pkg::MODE_READ;
	assign is_upd    = req.mode == ils_pkg::MODE_UPDATE;
	assign is_del    = req.mode == ils_pkg::MODE_DELETE;

	always_comb begin
		ctl.op_append = acc && is_app && !full;
		ctl.op_update = acc && is_upd && !oob;
		ctl.op_delete = acc && is_del && !oob;
		ctl.pos       = ils_pkg::POS_W'(req.index);
		ctl.count     = count_ext;
		ctl.value     = req.value;
	end

	always_comb begin
		count_nxt = count_ext;
		if (is_app && !full) begin
			count_nxt = count_ext + 1'b1;
		end else if (is_del && !oob) begin
			count_nxt = count_ext - 1'b1;
		end
	end

	always_comb begin
		if (is_app) begin
			st_nxt = full ? ils_pkg::ST_FULL : ils_pkg::ST_OK;
		end else begin
			st_nxt = oob ? ils_pkg::ST_OOB : ils_pkg::ST_OK;
		end
	end

	ils_chain #(.DEPTH(DEPTH)) u_chain (
		.clk    (clk),
		.ctl    (ctl),
		.rd_cap (acc),
		.rd_lo  (req.index[ils_pkg::GRP_SEL_W-1:0]),
		.grp_s1 (grp_s1)
	);

	always_comb begin
		if (rd_ok_s1) begin
			rd_word = grp_s1[grp_hi_s1];
		end else if (rd_oob_s1) begin
			rd_word = '1;
		end else begin
			rd_word = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			st_s1     <= st_nxt;
			cnt_s1    <= count_nxt[ils_pkg::CNT_OUT_W-1:0];
			rd_ok_s1  <= is_rd && !oob;
			rd_oob_s1 <= is_rd && oob;
			grp_hi_s1 <= req.index[ils_pkg::IDX_W-1:ils_pkg::GRP_SEL_W];
		end
	end

	// The second stage moves into the output register once it is free or being emptied.
	assign rsp_load = busy_q && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_nxt[CW-1:0];
			end
			if (acc) begin
				busy_q <= 1'b1;
			end else if (rsp_load) begin
				busy_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q <= rd_word;
			rsp_st_q   <= st_s1;
			rsp_cnt_q  <= cnt_s1;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;
	assign rsp.status    = rsp_st_q;
	assign rsp.count     = rsp_cnt_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ils_pkg::POS_W'(count_q) <= DEPTH_POS)
		else $error("element count exceeds capacity");

	a_delete_drops: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op_delete |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("good delete did not lower the count by one");

	a_full_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ils_pkg::ST_FULL |-> rsp.read_data == '0)
		else $error("refused append returned nonzero read data");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("second request taken while one is in flight");
`endif

endmodule
